// ----- sv/fat_chained_block_store_top_assert.svh -----
// assertion macros shared by the block store modules
// expects clk and rst_n in the scope of each use
`ifndef FAT_CHAINED_BLOCK_STORE_TOP_ASSERT_SVH
`define FAT_CHAINED_BLOCK_STORE_TOP_ASSERT_SVH

// same-cycle implication
`define FCBS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCBS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/fcbs_pkg.sv -----
// types, constants and codes of the linked-block file store
// used by fcbs_ctrl, fcbs_dpath and the top level
`timescale 1ns / 1ps

package fcbs_pkg;

    localparam int NUM_BLOCKS  = 64;
    localparam int BLOCK_BYTES = 16;
    localparam int STORE_BYTES = 1024;
    localparam logic [7:0] END_MARK = 8'd3;

    localparam int BLK_W   = $clog2(NUM_BLOCKS);
    localparam int LINK_W  = $clog2(NUM_BLOCKS + 1);
    localparam int OFF_W   = $clog2(BLOCK_BYTES);
    localparam int ADDR_W  = $clog2(STORE_BYTES);
    localparam int FADDR_W = BLK_W + OFF_W;
    localparam int LEN_W   = 11;
    localparam int POS_W   = 10;
    localparam int CNT_W   = $clog2(((NUM_BLOCKS > BLOCK_BYTES) ? NUM_BLOCKS : BLOCK_BYTES) + 1);

    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NUM_BLOCKS);

    localparam logic [2:0] REQ_CREATE = 3'd0;
    localparam logic [2:0] REQ_APPEND = 3'd1;
    localparam logic [2:0] REQ_ERASE  = 3'd2;
    localparam logic [2:0] REQ_DEEP   = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [2:0] BS_CUR_OFF   = 3'd0;
    localparam logic [2:0] BS_CUR_OFF1  = 3'd1;
    localparam logic [2:0] BS_FREE_HEAD = 3'd2;
    localparam logic [2:0] BS_CUR_CNT   = 3'd3;
    localparam logic [2:0] BS_CLEAR     = 3'd4;

    localparam logic [1:0] LS_CUR_END  = 2'd0;
    localparam logic [1:0] LS_CUR_FREE = 2'd1;
    localparam logic [1:0] LS_FREE_END = 2'd2;

    localparam logic DS_CREATE  = 1'b0;
    localparam logic DS_LEN_INC = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] name_key;
        logic [7:0]  data_byte;
        logic [9:0]  position;
    } req_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] block_index;
        logic [7:0] read_byte;
    } rsp_word_t;

    typedef struct packed {
        logic [31:0]      key;
        logic [BLK_W-1:0] first;
        logic [LEN_W-1:0] len;
    } dir_entry_t;

    typedef struct packed {
        logic       load;
        logic       scan;
        logic       scan_init;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       find_hit;
        logic       follow;
        logic       byte_we;
        logic [2:0] byte_sel;
        logic       link_we;
        logic [1:0] link_sel;
        logic       dir_we;
        logic       dir_sel;
        logic       used_set;
        logic       used_clr;
        logic       valid_set;
        logic       valid_clr;
        logic       res_full;
        logic       res_nf;
        logic       res_blk_cur;
        logic       res_blk_free;
        logic       res_rd_load;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       scan_last;
        logic       blk_none;
        logic       slot_none;
        logic       match;
        logic       link_next;
        logic       steps_max;
        logic       steps_last;
        logic       at_block;
        logic       off_last;
        logic       zero_last;
        logic       clr_last;
        logic       out_free;
    } dp_stat_t;

endpackage

// ----- sv/fcbs_dpath.sv -----
// datapath of the block store: link, directory and byte memories, counters, result
// depends on fcbs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "fat_chained_block_store_top_assert.svh"

module fcbs_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  fcbs_pkg::req_word_t req_word,
    input  fcbs_pkg::dp_cmd_t   cmd,
    output fcbs_pkg::dp_stat_t  stat,
    input  logic                rsp_stall,
    output logic                rsp_valid,
    output fcbs_pkg::rsp_word_t rsp_word
);
    import fcbs_pkg::*;

    function automatic logic [FADDR_W-1:0] faddr(input logic [BLK_W-1:0] blk,
                                                 input logic [OFF_W-1:0] off);
        faddr = FADDR_W'(blk) * FADDR_W'(BLOCK_BYTES) + FADDR_W'(off);
    endfunction

    logic [LINK_W-1:0] link_mem [NUM_BLOCKS];
    dir_entry_t        dir_mem  [NUM_BLOCKS];
    logic [7:0]        byte_mem [STORE_BYTES];

    req_word_t         in_reg, in_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic [CNT_W-1:0]  free_blk_reg, free_blk_next;
    logic [CNT_W-1:0]  free_slot_reg, free_slot_next;
    logic [BLK_W-1:0]  slot_reg, slot_next;
    logic [BLK_W-1:0]  first_reg, first_next;
    logic [BLK_W-1:0]  cur_reg, cur_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [NUM_BLOCKS-1:0] used_reg, used_next;
    logic [NUM_BLOCKS-1:0] valid_reg, valid_next;
    rsp_word_t         res_reg, res_next;
    rsp_word_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [LINK_W-1:0] link_rd_reg;
    dir_entry_t        dir_rd_reg;
    logic [7:0]        byte_rd_reg;
    logic              byte_ok_reg;

    logic [BLK_W-1:0]  ci;
    logic [BLK_W-1:0]  free_idx;
    logic [BLK_W-1:0]  slot_idx;
    logic [OFF_W-1:0]  len_off;
    logic [OFF_W-1:0]  pos_off;
    logic [POS_W-1:0]  pos_blk;
    logic [FADDR_W-1:0] wfa;
    logic [FADDR_W-1:0] rfa;
    logic [ADDR_W-1:0] byte_wa;
    logic [7:0]        byte_wd;
    logic              byte_wok;
    logic [BLK_W-1:0]  link_wa;
    logic [LINK_W-1:0] link_wd;
    logic [BLK_W-1:0]  dir_wa;
    dir_entry_t        dir_wd;

    assign ci       = cnt_reg[BLK_W-1:0];
    assign free_idx = free_blk_reg[BLK_W-1:0];
    assign slot_idx = free_slot_reg[BLK_W-1:0];
    assign len_off  = OFF_W'(len_reg % BLOCK_BYTES);
    assign pos_off  = OFF_W'(in_reg.position % BLOCK_BYTES);
    assign pos_blk  = POS_W'(in_reg.position / BLOCK_BYTES);
    assign rfa      = faddr(cur_reg, pos_off);

    always_comb
    begin
        wfa      = faddr(cur_reg, len_off);
        byte_wd  = '0;
        unique case (cmd.byte_sel)
            BS_CUR_OFF:
            begin
                wfa     = faddr(cur_reg, len_off);
                byte_wd = in_reg.data_byte;
            end
            BS_CUR_OFF1:
            begin
                wfa     = faddr(cur_reg, OFF_W'(len_off + 1'b1));
                byte_wd = END_MARK;
            end
            BS_FREE_HEAD:
            begin
                wfa     = faddr(free_idx, '0);
                byte_wd = END_MARK;
            end
            BS_CUR_CNT:
            begin
                wfa     = faddr(cur_reg, OFF_W'(cnt_reg));
                byte_wd = '0;
            end
            default:
            begin
                wfa     = '0;
                byte_wd = '0;
            end
        endcase
        if (cmd.byte_sel == BS_CLEAR)
        begin
            byte_wa  = clr_reg;
            byte_wok = 1'b1;
        end
        else
        begin
            byte_wa  = ADDR_W'(wfa);
            byte_wok = (int'(wfa) < STORE_BYTES);
        end
    end

    always_comb
    begin
        unique case (cmd.link_sel)
            LS_CUR_END:
            begin
                link_wa = cur_reg;
                link_wd = LINK_END;
            end
            LS_CUR_FREE:
            begin
                link_wa = cur_reg;
                link_wd = LINK_W'(free_blk_reg);
            end
            LS_FREE_END:
            begin
                link_wa = free_idx;
                link_wd = LINK_END;
            end
            default:
            begin
                link_wa = cur_reg;
                link_wd = LINK_END;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.dir_sel)
            DS_CREATE:
            begin
                dir_wa = slot_idx;
                dir_wd = '{key: in_reg.name_key, first: free_idx, len: '0};
            end
            DS_LEN_INC:
            begin
                dir_wa = slot_reg;
                dir_wd = '{key: in_reg.name_key, first: first_reg,
                           len: LEN_W'(len_reg + 1'b1)};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        link_rd_reg <= link_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dir_we)
        begin
            dir_mem[dir_wa] <= dir_wd;
        end
        dir_rd_reg <= dir_mem[ci];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.byte_we && byte_wok)
        begin
            byte_mem[byte_wa] <= byte_wd;
        end
        byte_rd_reg <= byte_mem[ADDR_W'(rfa)];
        byte_ok_reg <= (int'(rfa) < STORE_BYTES);
    end

    always_comb
    begin
        in_next        = in_reg;
        cnt_next       = cnt_reg;
        steps_next     = steps_reg;
        free_blk_next  = free_blk_reg;
        free_slot_next = free_slot_reg;
        slot_next      = slot_reg;
        first_next     = first_reg;
        cur_next       = cur_reg;
        len_next       = len_reg;
        clr_next       = clr_reg;
        used_next      = used_reg;
        valid_next     = valid_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load)
        begin
            in_next        = req_word;
            cnt_next       = '0;
            steps_next     = '0;
            free_blk_next  = CNT_W'(NUM_BLOCKS);
            free_slot_next = CNT_W'(NUM_BLOCKS);
            res_next       = '{status: ST_OK, block_index: '0, read_byte: '0};
        end
        if (cmd.scan_init)
        begin
            cnt_next      = '0;
            free_blk_next = CNT_W'(NUM_BLOCKS);
        end
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        if (cmd.cnt_inc)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        if (cmd.scan)
        begin
            if (!used_reg[ci] && stat.blk_none)
            begin
                free_blk_next = cnt_reg;
            end
            if (!valid_reg[ci] && stat.slot_none)
            begin
                free_slot_next = cnt_reg;
            end
        end
        if (cmd.find_hit)
        begin
            slot_next  = ci;
            first_next = dir_rd_reg.first;
            cur_next   = dir_rd_reg.first;
            len_next   = dir_rd_reg.len;
            steps_next = '0;
        end
        if (cmd.follow)
        begin
            cur_next   = link_rd_reg[BLK_W-1:0];
            steps_next = CNT_W'(steps_reg + 1'b1);
        end
        if (cmd.dir_we && (cmd.dir_sel == DS_LEN_INC))
        begin
            len_next = LEN_W'(len_reg + 1'b1);
        end
        if (cmd.used_set)
        begin
            used_next[free_idx] = 1'b1;
        end
        if (cmd.used_clr)
        begin
            used_next[cur_reg] = 1'b0;
        end
        if (cmd.valid_set)
        begin
            valid_next[slot_idx] = 1'b1;
        end
        if (cmd.valid_clr)
        begin
            valid_next[slot_reg] = 1'b0;
        end
        if (cmd.byte_we && (cmd.byte_sel == BS_CLEAR))
        begin
            clr_next = ADDR_W'(clr_reg + 1'b1);
        end
        if (cmd.res_full)
        begin
            res_next.status = ST_FULL;
        end
        if (cmd.res_nf)
        begin
            res_next.status = ST_NOT_FOUND;
        end
        if (cmd.res_blk_cur)
        begin
            res_next.block_index = cur_reg;
        end
        if (cmd.res_blk_free)
        begin
            res_next.block_index = free_idx;
        end
        if (cmd.res_rd_load)
        begin
            res_next.read_byte = byte_ok_reg ? byte_rd_reg : 8'd0;
        end
        if (cmd.out_load)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            steps_reg     <= '0;
            free_blk_reg  <= CNT_W'(NUM_BLOCKS);
            free_slot_reg <= CNT_W'(NUM_BLOCKS);
            clr_reg       <= '0;
            used_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            steps_reg     <= steps_next;
            free_blk_reg  <= free_blk_next;
            free_slot_reg <= free_slot_next;
            clr_reg       <= clr_next;
            used_reg      <= used_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg    <= in_next;
        slot_reg  <= slot_next;
        first_reg <= first_next;
        cur_reg   <= cur_next;
        len_reg   <= len_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        stat.req_type   = in_reg.req_type;
        stat.scan_last  = (cnt_reg == CNT_W'(NUM_BLOCKS - 1));
        stat.blk_none   = (free_blk_reg == CNT_W'(NUM_BLOCKS));
        stat.slot_none  = (free_slot_reg == CNT_W'(NUM_BLOCKS));
        stat.match      = valid_reg[ci] && (dir_rd_reg.key == in_reg.name_key);
        stat.link_next  = (link_rd_reg < LINK_W'(NUM_BLOCKS));
        stat.steps_max  = (steps_reg == CNT_W'(NUM_BLOCKS));
        stat.steps_last = (steps_reg == CNT_W'(NUM_BLOCKS - 1));
        stat.at_block   = (POS_W'(steps_reg) == pos_blk);
        stat.off_last   = (len_off == OFF_W'(BLOCK_BYTES - 1));
        stat.zero_last  = (cnt_reg == CNT_W'(BLOCK_BYTES - 1));
        stat.clr_last   = (clr_reg == ADDR_W'(STORE_BYTES - 1));
        stat.out_free   = !out_valid_reg || !rsp_stall;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_reg;

    `FCBS_ASSERT_IMPL(a_used_set_blk, cmd.used_set, !stat.blk_none, "block taken with none free")
    `FCBS_ASSERT_IMPL(a_valid_set_slot, cmd.valid_set, !stat.slot_none, "slot taken with none free")
    `FCBS_ASSERT_IMPL(a_out_no_overwrite, cmd.out_load, stat.out_free, "result word overwritten")

endmodule

// ----- sv/fcbs_ctrl.sv -----
// controller state machine of the block store, drives fcbs_dpath by command word
// depends on fcbs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "fat_chained_block_store_top_assert.svh"

module fcbs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  fcbs_pkg::dp_stat_t stat,
    output fcbs_pkg::dp_cmd_t  cmd
);
    import fcbs_pkg::*;

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DISPATCH = 5'd2;
    localparam logic [4:0] S_CSCAN    = 5'd3;
    localparam logic [4:0] S_CFIN     = 5'd4;
    localparam logic [4:0] S_FIND_RD  = 5'd5;
    localparam logic [4:0] S_FIND_CMP = 5'd6;
    localparam logic [4:0] S_AW_RD    = 5'd7;
    localparam logic [4:0] S_AW_CHK   = 5'd8;
    localparam logic [4:0] S_AP_DEC   = 5'd9;
    localparam logic [4:0] S_AP_W1    = 5'd10;
    localparam logic [4:0] S_AP_W2    = 5'd11;
    localparam logic [4:0] S_AP_SCAN  = 5'd12;
    localparam logic [4:0] S_AP_NB    = 5'd13;
    localparam logic [4:0] S_AP_NB2   = 5'd14;
    localparam logic [4:0] S_ER_INV   = 5'd15;
    localparam logic [4:0] S_ER_RD    = 5'd16;
    localparam logic [4:0] S_ER_CHK   = 5'd17;
    localparam logic [4:0] S_ER_ZERO  = 5'd18;
    localparam logic [4:0] S_ER_FREE  = 5'd19;
    localparam logic [4:0] S_ER_END   = 5'd20;
    localparam logic [4:0] S_RD_RD    = 5'd21;
    localparam logic [4:0] S_RD_CHK   = 5'd22;
    localparam logic [4:0] S_RD_BYTE  = 5'd23;
    localparam logic [4:0] S_RD_DATA  = 5'd24;
    localparam logic [4:0] S_DONE     = 5'd25;

    logic [4:0] state_reg, state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.byte_we  = 1'b1;
                cmd.byte_sel = BS_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (stat.req_type == REQ_CREATE)
                begin
                    state_next = S_CSCAN;
                end
                else if ((stat.req_type == REQ_APPEND) || (stat.req_type == REQ_ERASE)
                         || (stat.req_type == REQ_DEEP) || (stat.req_type == REQ_READ))
                begin
                    state_next = S_FIND_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CSCAN:
            begin
                cmd.scan    = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_CFIN;
                end
            end
            S_CFIN:
            begin
                if (stat.blk_none || stat.slot_none)
                begin
                    cmd.res_full = 1'b1;
                end
                else
                begin
                    cmd.valid_set    = 1'b1;
                    cmd.dir_we       = 1'b1;
                    cmd.dir_sel      = DS_CREATE;
                    cmd.used_set     = 1'b1;
                    cmd.link_we      = 1'b1;
                    cmd.link_sel     = LS_FREE_END;
                    cmd.res_blk_free = 1'b1;
                end
                state_next = S_DONE;
            end
            S_FIND_RD:
            begin
                state_next = S_FIND_CMP;
            end
            S_FIND_CMP:
            begin
                if (stat.match)
                begin
                    cmd.find_hit = 1'b1;
                    priority if (stat.req_type == REQ_APPEND)
                    begin
                        state_next = S_AW_RD;
                    end
                    else if ((stat.req_type == REQ_ERASE) || (stat.req_type == REQ_DEEP))
                    begin
                        state_next = S_ER_INV;
                    end
                    else
                    begin
                        state_next = S_RD_RD;
                    end
                end
                else if (stat.scan_last)
                begin
                    cmd.res_nf = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FIND_RD;
                end
            end
            S_AW_RD:
            begin
                state_next = S_AW_CHK;
            end
            S_AW_CHK:
            begin
                if (stat.link_next && !stat.steps_max)
                begin
                    cmd.follow = 1'b1;
                    state_next = S_AW_RD;
                end
                else
                begin
                    state_next = S_AP_DEC;
                end
            end
            S_AP_DEC:
            begin
                if (stat.off_last)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_AP_SCAN;
                end
                else
                begin
                    state_next = S_AP_W1;
                end
            end
            S_AP_W1:
            begin
                cmd.byte_we  = 1'b1;
                cmd.byte_sel = BS_CUR_OFF;
                cmd.link_we  = 1'b1;
                cmd.link_sel = LS_CUR_END;
                state_next   = S_AP_W2;
            end
            S_AP_W2:
            begin
                cmd.byte_we     = 1'b1;
                cmd.byte_sel    = BS_CUR_OFF1;
                cmd.dir_we      = 1'b1;
                cmd.dir_sel     = DS_LEN_INC;
                cmd.res_blk_cur = 1'b1;
                state_next      = S_DONE;
            end
            S_AP_SCAN:
            begin
                cmd.scan    = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_AP_NB;
                end
            end
            S_AP_NB:
            begin
                if (stat.blk_none)
                begin
                    cmd.res_full    = 1'b1;
                    cmd.res_blk_cur = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.byte_we  = 1'b1;
                    cmd.byte_sel = BS_CUR_OFF;
                    cmd.link_we  = 1'b1;
                    cmd.link_sel = LS_CUR_FREE;
                    cmd.used_set = 1'b1;
                    state_next   = S_AP_NB2;
                end
            end
            S_AP_NB2:
            begin
                cmd.link_we      = 1'b1;
                cmd.link_sel     = LS_FREE_END;
                cmd.byte_we      = 1'b1;
                cmd.byte_sel     = BS_FREE_HEAD;
                cmd.dir_we       = 1'b1;
                cmd.dir_sel      = DS_LEN_INC;
                cmd.res_blk_free = 1'b1;
                state_next       = S_DONE;
            end
            S_ER_INV:
            begin
                cmd.valid_clr = 1'b1;
                state_next    = S_ER_RD;
            end
            S_ER_RD:
            begin
                cmd.cnt_clr = 1'b1;
                state_next  = S_ER_CHK;
            end
            S_ER_CHK:
            begin
                state_next = (stat.req_type == REQ_DEEP) ? S_ER_ZERO : S_ER_FREE;
            end
            S_ER_ZERO:
            begin
                cmd.byte_we  = 1'b1;
                cmd.byte_sel = BS_CUR_CNT;
                cmd.cnt_inc  = 1'b1;
                if (stat.zero_last)
                begin
                    state_next = S_ER_FREE;
                end
            end
            S_ER_FREE:
            begin
                cmd.used_clr = 1'b1;
                if (!stat.link_next)
                begin
                    cmd.res_blk_cur = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.follow = 1'b1;
                    state_next = stat.steps_last ? S_ER_END : S_ER_RD;
                end
            end
            S_ER_END:
            begin
                cmd.res_blk_cur = 1'b1;
                state_next      = S_DONE;
            end
            S_RD_RD:
            begin
                state_next = stat.at_block ? S_RD_BYTE : S_RD_CHK;
            end
            S_RD_CHK:
            begin
                if (stat.link_next)
                begin
                    cmd.follow = 1'b1;
                    state_next = S_RD_RD;
                end
                else
                begin
                    state_next = S_RD_BYTE;
                end
            end
            S_RD_BYTE:
            begin
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                cmd.res_rd_load = 1'b1;
                cmd.res_blk_cur = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `FCBS_ASSERT_NEXT(a_hit_dispatch, (state_reg == S_FIND_CMP) && stat.match, (state_reg == S_AW_RD) || (state_reg == S_ER_INV) || (state_reg == S_RD_RD), "bad state after name hit")
    `FCBS_ASSERT_IMPL(a_follow_link, cmd.follow, stat.link_next, "followed a chain end")
    `FCBS_ASSERT_NEXT(a_clear_hold, (state_reg == S_CLEAR) && !stat.clr_last, state_reg == S_CLEAR, "clearing pass left early")

endmodule

// ----- sv/fat_chained_block_store_top.sv -----
// top level of the linked-block file store
// joins fcbs_ctrl and fcbs_dpath; depends on fcbs_pkg
//
// request channel: req_valid, req_stall, req_word (type, name key, data byte, position)
// response channel: rsp_valid, rsp_stall, rsp_word (status, block index, read byte)
// one response word per request word, in order
// after reset the whole byte store is zeroed one byte a cycle, with req_stall high
// one request is worked at a time; req_stall is low only while idle
// steps from accept to result; the link and directory memories have registered reads:
//   unknown type goes straight to the result; create scans all block and slot flags
//   others first search the directory slot by slot up to the match (at most 64 slots)
//   append then walks the chain block by block and writes, or rescans when a block fills
//   read walks the chain block by block up to the position
//   erase frees the chain block by block; deep erase also zeroes each block's bytes
// the controller returns to idle before the next request is taken
// the finished word sits in an output register; a new request is taken while it waits
// a stall on rsp_stall holds that word, and a following result waits until it leaves
`timescale 1ns / 1ps

module fat_chained_block_store_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  fcbs_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output fcbs_pkg::rsp_word_t rsp_word
);
    import fcbs_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fcbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    fcbs_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_word  (rsp_word)
    );

endmodule
